// ===== hw/rtl/fuct_pkg.sv =====
// Shared constants for the first-unique-character tracker: widths, store depth and status codes.
package fuct_pkg;

  localparam int CHAR_W = 8;
  localparam int MAX_DEPTH = 1 << CHAR_W;
  localparam int ALPHABET_SIZE_DEFAULT = 256;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_UNSEEN = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ONCE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REPEATED = 2'd2;

endpackage

// ===== hw/rtl/fuct_status_mem.sv =====
// Per-character status memory with a clearing pass after reset and same-edge write forwarding.
module fuct_status_mem import fuct_pkg::*; #(
  parameter int DEPTH = MAX_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  output logic                busy,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic [STATUS_W-1:0] rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [STATUS_W-1:0] wr_data
);

  logic [STATUS_W-1:0] status_ram [DEPTH];
  logic [STATUS_W-1:0] ram_q;
  logic [STATUS_W-1:0] fwd_data;
  logic                fwd_sel;
  logic [IDX_W-1:0]    clr_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [STATUS_W-1:0] mem_wd;

  // The clearing pass owns the write port until every entry reads as unseen.
  assign mem_we = busy || wr_en;
  assign mem_wa = busy ? clr_addr : wr_addr;
  assign mem_wd = busy ? ST_UNSEEN : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      status_ram[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      ram_q <= status_ram[rd_addr];
    end
  end

  // A write landing on the same edge as the read is missed by the array, so keep it aside.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_sel <= mem_we && (mem_wa == rd_addr);
      fwd_data <= mem_wd;
    end
  end

  assign rd_data = fwd_sel ? fwd_data : ram_q;

endmodule

// ===== hw/rtl/fuct_link_mem.sv =====
// One list-link memory (previous or next pointers) with same-edge write forwarding.
module fuct_link_mem import fuct_pkg::*; #(
  parameter int DEPTH = MAX_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data
);

  logic [IDX_W-1:0] link_ram [DEPTH];
  logic [IDX_W-1:0] ram_q;
  logic [IDX_W-1:0] fwd_data;
  logic             fwd_sel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_ram[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q <= link_ram[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_sel <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_sel ? fwd_data : ram_q;

endmodule

// ===== hw/rtl/first_unique_char_tracker.sv =====
// Top level of the first-unique-character tracker: list control, pipeline and output register.
//
// Usage: the input channel (in_valid, in_stall, char_in) carries one byte of a character
// stream per beat. For every accepted beat the output channel (out_valid, out_stall,
// has_unique, first_unique) delivers exactly one beat: has_unique is 1 when some byte has
// been seen exactly once so far, and first_unique is the earliest such byte (0 otherwise).
// Bytes at or above ALPHABET_SIZE leave the state alone and still report the current answer.
// An accepted byte is registered in the update stage, and its result is loaded into the output
// register as that stage retires; it is offered there until the beat is taken.
// Throughput: one byte per cycle unless out_stall holds the output. The status, previous-link
// and next-link memories are each read once per accepted byte and written at most once as it
// retires; a write on the next read's edge is forwarded: back-to-back bytes need no bubble.
// Reset: rst is synchronous. It empties the list and starts a clearing pass over the status
// memory over its min(ALPHABET_SIZE, 256) entries, during which in_stall stays high.
// Backpressure: a finished result waits in the output register while out_stall is high. One
// more byte can be accepted and read meanwhile; it then holds in the update stage, and
// in_stall rises until the output register frees up. Nothing is lost or repeated.
module first_unique_char_tracker import fuct_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] char_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              has_unique,
  output logic [CHAR_W-1:0] first_unique
);

  // Only byte values below both the alphabet size and 256 can ever touch the stores.
  localparam int DEPTH = (ALPHABET_SIZE < MAX_DEPTH) ? ALPHABET_SIZE : MAX_DEPTH;
  localparam int IDX_W = $clog2(DEPTH);

  logic                in_accept;
  logic                in_range;
  logic [IDX_W-1:0]    in_idx;
  logic                clr_busy;

  // Update stage: the byte whose memory reads are in flight.
  logic                s1_valid;
  logic                s1_in_range;
  logic [IDX_W-1:0]    s1_idx;
  logic                s1_adv;

  logic [STATUS_W-1:0] st_rd;
  logic [IDX_W-1:0]    pv_rd;
  logic [IDX_W-1:0]    nx_rd;

  logic                st_wr_en;
  logic [STATUS_W-1:0] st_wr_data;
  logic                nx_wr_en;
  logic [IDX_W-1:0]    nx_wr_addr;
  logic [IDX_W-1:0]    nx_wr_data;
  logic                pv_wr_en;
  logic [IDX_W-1:0]    pv_wr_addr;
  logic [IDX_W-1:0]    pv_wr_data;

  // List bookkeeping kept in registers.
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    head_next;
  logic [IDX_W-1:0]    tail;
  logic [IDX_W-1:0]    tail_next;
  logic                nonempty;
  logic                nonempty_next;
  logic                at_head;
  logic                at_tail;

  // The update stage retires when the output register is empty or being emptied.
  assign s1_adv = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clr_busy || (s1_valid && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  assign in_range = (32'(char_in) < 32'(DEPTH));
  assign in_idx = char_in[IDX_W-1:0];

  fuct_status_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_status (
    .clk     (clk),
    .rst     (rst),
    .busy    (clr_busy),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (st_rd),
    .wr_en   (st_wr_en && s1_adv),
    .wr_addr (s1_idx),
    .wr_data (st_wr_data)
  );

  fuct_link_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_prev (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (pv_rd),
    .wr_en   (pv_wr_en && s1_adv),
    .wr_addr (pv_wr_addr),
    .wr_data (pv_wr_data)
  );

  fuct_link_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_next (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (nx_rd),
    .wr_en   (nx_wr_en && s1_adv),
    .wr_addr (nx_wr_addr),
    .wr_data (nx_wr_data)
  );

  assign at_head = (head == s1_idx);
  assign at_tail = (tail == s1_idx);

  // A first sighting appends at the tail; a second one unlinks the byte from its neighbors.
  // Each link memory takes at most one write per byte, so one port each is enough.
  always_comb begin
    st_wr_en = 1'b0;
    st_wr_data = ST_ONCE;
    nx_wr_en = 1'b0;
    nx_wr_addr = tail;
    nx_wr_data = s1_idx;
    pv_wr_en = 1'b0;
    pv_wr_addr = s1_idx;
    pv_wr_data = tail;
    head_next = head;
    tail_next = tail;
    nonempty_next = nonempty;
    if (s1_valid && s1_in_range) begin
      case (st_rd)
        ST_UNSEEN: begin
          st_wr_en = 1'b1;
          st_wr_data = ST_ONCE;
          tail_next = s1_idx;
          if (!nonempty) begin
            head_next = s1_idx;
            nonempty_next = 1'b1;
          end else begin
            nx_wr_en = 1'b1;
            pv_wr_en = 1'b1;
          end
        end
        ST_ONCE: begin
          st_wr_en = 1'b1;
          st_wr_data = ST_REPEATED;
          if (nonempty) begin
            if (at_head && at_tail) begin
              nonempty_next = 1'b0;
            end else begin
              if (at_head) begin
                head_next = nx_rd;
              end else begin
                nx_wr_en = 1'b1;
                nx_wr_addr = pv_rd;
                nx_wr_data = nx_rd;
              end
              if (at_tail) begin
                tail_next = pv_rd;
              end else begin
                pv_wr_en = 1'b1;
                pv_wr_addr = nx_rd;
                pv_wr_data = pv_rd;
              end
            end
          end
        end
        default: begin
          // Repeated bytes, and the unused status code, change nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_idx <= in_idx;
      s1_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      nonempty <= 1'b0;
    end else if (s1_adv) begin
      head <= head_next;
      tail <= tail_next;
      nonempty <= nonempty_next;
    end
  end

  // Output register: loaded as the update stage retires, dropped once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      has_unique <= nonempty_next;
      first_unique <= nonempty_next ? CHAR_W'(head_next) : '0;
    end
  end

endmodule
